### rtl/elcps_pkg.sv
// Shared types and constants for the exact-length cycle and path search block.
package elcps_pkg;

  // Graph size; vertex fields and the witness are five bits wide.
  localparam int MAX_VERTICES = 32;

  typedef enum logic [1:0] {
    OP_EDGE  = 2'd0,
    OP_CYCLE = 2'd1,
    OP_PATH  = 2'd2,
    OP_CLEAR = 2'd3
  } opcode_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [4:0] vertex_a;
    logic [4:0] vertex_b;
    logic       edge_present;
    logic [5:0] length;
  } req_t;

  typedef struct packed {
    logic       found;
    logic [4:0] witness_vertex;
    logic       last;
  } rsp_t;

  // Classified command handed from the front end to the search engine.
  typedef struct packed {
    logic       is_path;
    logic       doable;
    logic [4:0] src;
    logic [4:0] dst;
    logic [5:0] length;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_STEP,
    ST_EMIT,
    ST_FAIL
  } eng_state_e;

endpackage

### rtl/exact_length_cycle_path_search.sv
// Top level of the exact-length cycle and path search block.
//
// Holds an undirected graph of up to MAX_VERTICES (32) vertices as an
// adjacency bit matrix. Edge writes and clears take effect at the edge they
// are accepted and produce no results; busy holds them off while any query is
// queued or being searched, so every search sees the graph as it stood when
// its request arrived. Cycle and path queries are range checked by the front
// end, queued (two deep), and run by a depth-first search engine. A query
// leaves the queue; the engine then sets up a walk for each start vertex
// tried, takes forward steps and end-of-walk checks, reloads the stack frame
// on each step back, and then emits the results; a query that is out
// of range or finds nothing ends with a single result. Run time therefore
// depends on the graph and can be long; for queries busy is high only while
// the queue is full. Results leave on result_o, one per cycle, with
// result_valid_o high for exactly one cycle each; the receiver cannot stall
// them. A found query gives one result per witness vertex, the last flagged;
// otherwise one result with found low. vertex_count may be written only while
// the block is idle.
module exact_length_cycle_path_search
  import elcps_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  req_t       req_i,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [5:0] cfg_data_i,
  output logic       result_valid_o,
  output rsp_t       result_o
);
  localparam int VW = $clog2(MAX_VERTICES);

  logic [MAX_VERTICES-1:0] adj_q [MAX_VERTICES];
  logic [5:0] vcount_q;
  logic [6:0] n;
  logic       accept, is_query, q_full, q_empty, pop;
  cmd_t       cmd;
  logic       eng_busy;

  assign n = ({1'b0, vcount_q} > 7'(MAX_VERTICES)) ? 7'(MAX_VERTICES) : {1'b0, vcount_q};
  assign cfg_ready_o = 1'b1;
  assign is_query = (req_i.opcode == OP_CYCLE) || (req_i.opcode == OP_PATH);
  // Hold graph changes until every queued or running search is done.
  assign busy   = q_full || (!is_query && (!q_empty || eng_busy));
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= 6'd32;
      for (int i = 0; i < MAX_VERTICES; i++) adj_q[i] <= '0;
    end else begin
      if (cfg_valid_i) vcount_q <= cfg_data_i;
      if (accept && req_i.opcode == OP_CLEAR) begin
        for (int i = 0; i < MAX_VERTICES; i++) adj_q[i] <= '0;
      end else if (accept && req_i.opcode == OP_EDGE && req_i.vertex_a != req_i.vertex_b &&
                   32'(req_i.vertex_a) < 32'(MAX_VERTICES) &&
                   32'(req_i.vertex_b) < 32'(MAX_VERTICES)) begin
        adj_q[req_i.vertex_a[VW-1:0]][req_i.vertex_b[VW-1:0]] <= req_i.edge_present;
        adj_q[req_i.vertex_b[VW-1:0]][req_i.vertex_a[VW-1:0]] <= req_i.edge_present;
      end
    end
  end

  elcps_front u_front (
    .clk_i, .rst_ni, .push_i(accept && is_query), .req_i, .n_i(n),
    .full_o(q_full), .empty_o(q_empty), .pop_i(pop), .cmd_o(cmd)
  );

  elcps_engine u_engine (
    .clk_i, .rst_ni, .cmd_valid_i(!q_empty), .cmd_i(cmd), .cmd_pop_o(pop), .n_i(n),
    .adj_row_i(adj_q), .busy_o(eng_busy), .rsp_valid_o(result_valid_o), .rsp_o(result_o)
  );
endmodule

### rtl/elcps_ram.sv
// Generic single-port-write RAM with registered read.
module elcps_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### rtl/elcps_front.sv
// Front end: range checks each search request and queues it for the engine.
module elcps_front
  import elcps_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  req_t       req_i,
  input  logic [6:0] n_i,
  output logic       full_o,
  output logic       empty_o,
  input  logic       pop_i,
  output cmd_t       cmd_o
);
  // Two-entry queue.
  cmd_t       slot_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       rd_q, rd_d;
  cmd_t       cmd;
  logic [6:0] len7;

  always_comb begin
    len7        = {1'b0, req_i.length};
    cmd.is_path = (req_i.opcode == OP_PATH);
    cmd.src     = req_i.vertex_a;
    cmd.dst     = req_i.vertex_b;
    cmd.length  = req_i.length;
    if (cmd.is_path) begin
      cmd.doable = ({2'b0, req_i.vertex_a} < n_i) && ({2'b0, req_i.vertex_b} < n_i) &&
                   (len7 + 7'd1 <= n_i) && (len7 + 7'd1 <= 7'd32);
    end else begin
      cmd.doable = (len7 >= 7'd3) && (len7 <= n_i) && (len7 <= 7'd32);
    end
  end

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign cmd_o   = slot_q[rd_q];

  always_comb begin
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    rd_d  = pop_i ? ~rd_q : rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      rd_q  <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[rd_q ^ cnt_q[0]] <= cmd;
    end
  end
endmodule

### rtl/elcps_engine.sv
// Back end: depth-first search engine over the adjacency matrix.
module elcps_engine
  import elcps_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cmd_valid_i,
  input  cmd_t                    cmd_i,
  output logic                    cmd_pop_o,
  input  logic [6:0]              n_i,
  input  logic [MAX_VERTICES-1:0] adj_row_i [MAX_VERTICES],
  output logic                    busy_o,
  output logic                    rsp_valid_o,
  output rsp_t                    rsp_o
);
  localparam int VW = $clog2(MAX_VERTICES);

  eng_state_e state_q, state_d;
  cmd_t       cmd_q;
  logic [4:0] s_q, s_d;            // cycle start vertex
  logic [5:0] d_q, d_d;            // walk depth
  logic [6:0] nxt_q, nxt_d;        // next candidate at current depth
  logic [4:0] cur_q, cur_d;        // vertex at current depth
  logic [31:0] vis_q, vis_d;
  logic [5:0] k_q, k_d;            // emit index
  logic [5:0] cnt;                 // witness count

  // Stacks as RAMs; vertex stack also read for emit.
  logic        vs_we, ns_we;
  logic [4:0]  vs_wa, ns_wa, vs_ra, ns_ra;
  logic [4:0]  vs_wd, vs_rd;
  logic [5:0]  ns_wd, ns_rd;

  elcps_ram #(.Width(5), .Depth(32)) u_vstack (
    .clk_i, .we_i(vs_we), .waddr_i(vs_wa), .wdata_i(vs_wd), .raddr_i(vs_ra), .rdata_o(vs_rd)
  );
  elcps_ram #(.Width(6), .Depth(32)) u_nstack (
    .clk_i, .we_i(ns_we), .waddr_i(ns_wa), .wdata_i(ns_wd), .raddr_i(ns_ra), .rdata_o(ns_rd)
  );

  // Pop phase flag: after backtrack, the stacks are read and reloaded.
  logic pop_q, pop_d;

  logic [31:0] row, cand;
  logic [31:0] lowmask;
  logic        hit;
  logic [4:0]  w;
  logic [4:0]  base;
  logic [4:0]  endv;

  always_comb begin
    row = '0;
    row[MAX_VERTICES-1:0] = adj_row_i[cur_q[VW-1:0]];
  end

  assign cnt  = cmd_q.is_path ? cmd_q.length + 6'd1 : cmd_q.length;
  assign base = cmd_q.is_path ? 5'd0 : s_q;

  // Candidate set: neighbors, unvisited, at/above nxt, below n; a path target only on the final step.
  always_comb begin
    lowmask = '0;
    for (int i = 0; i < 32; i++) begin
      lowmask[i] = ({2'b0, 5'(i)} >= nxt_q) && ({2'b0, 5'(i)} < n_i);
    end
    cand = row & ~vis_q & lowmask;
    if (cmd_q.is_path && (cmd_q.length - d_q != 6'd1)) begin
      cand[cmd_q.dst] = 1'b0;
    end
    hit = |cand;
    w = '0;
    for (int i = 31; i >= 0; i--) begin
      if (cand[i]) w = 5'(i);
    end
    endv = cmd_q.is_path ? cmd_q.dst : s_q;
  end

  always_comb begin
    state_d = state_q;
    s_d = s_q; d_d = d_q; nxt_d = nxt_q; cur_d = cur_q; vis_d = vis_q; k_d = k_q;
    pop_d = 1'b0;
    vs_we = 1'b0; vs_wa = d_q[4:0]; vs_wd = cur_q;
    ns_we = 1'b0; ns_wa = d_q[4:0]; ns_wd = nxt_q[5:0];
    vs_ra = d_q[4:0]; ns_ra = d_q[4:0];
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          state_d = cmd_i.doable ? ST_INIT : ST_FAIL;
          s_d = 5'd0;
        end
      end
      ST_INIT: begin
        d_d   = 6'd0;
        cur_d = cmd_q.is_path ? cmd_q.src : s_q;
        nxt_d = cmd_q.is_path ? 7'd0 : {2'b0, s_q};
        vis_d = 32'd1 << (cmd_q.is_path ? cmd_q.src : s_q);
        vs_we = 1'b1; vs_wa = 5'd0; vs_wd = cmd_q.is_path ? cmd_q.src : s_q;
        state_d = ST_STEP;
      end
      ST_STEP: begin
        if (pop_q) begin
          // Restore frame at new depth from the stacks.
          cur_d = vs_rd;
          nxt_d = {1'b0, ns_rd};
        end else if (cmd_q.is_path ? (d_q == cmd_q.length) : (d_q == cmd_q.length - 6'd1)) begin
          if (cmd_q.is_path ? (cur_q == endv) : row[s_q]) begin
            k_d = 6'd0; vs_ra = 5'd0; state_d = ST_EMIT;
          end else begin
            state_d = ST_STEP;
          end
          if (!(cmd_q.is_path ? (cur_q == endv) : row[s_q])) begin
            // backtrack
            if (d_q == 6'd0) begin
              state_d = ST_FAIL;
            end else begin
              vis_d[cur_q] = 1'b0; d_d = d_q - 6'd1;
              vs_ra = 5'(d_q - 6'd1); ns_ra = 5'(d_q - 6'd1); pop_d = 1'b1;
            end
          end
        end else if (hit) begin
          ns_we = 1'b1; ns_wa = d_q[4:0]; ns_wd = {1'b0, w} + 6'd1;
          vs_we = 1'b1; vs_wa = 5'(d_q + 6'd1); vs_wd = w;
          d_d = d_q + 6'd1; cur_d = w; nxt_d = {2'b0, base}; vis_d[w] = 1'b1;
        end else if (d_q == 6'd0) begin
          if (!cmd_q.is_path && ({2'b0, s_q} + 7'd1 < n_i)) begin
            s_d = s_q + 5'd1; state_d = ST_INIT;
          end else begin
            state_d = ST_FAIL;
          end
        end else begin
          vis_d[cur_q] = 1'b0; d_d = d_q - 6'd1;
          vs_ra = 5'(d_q - 6'd1); ns_ra = 5'(d_q - 6'd1); pop_d = 1'b1;
        end
        // A fail at depth zero on a cycle advances the start vertex while one is left.
        if (state_d == ST_FAIL && !cmd_q.is_path && d_q == 6'd0 && !pop_q &&
            ({2'b0, s_q} + 7'd1 < n_i)) begin
          s_d = s_q + 5'd1; state_d = ST_INIT;
        end
      end
      ST_EMIT: begin
        vs_ra = 5'(k_q + 6'd1);
        k_d = k_q + 6'd1;
        if (k_q + 6'd1 == cnt) state_d = ST_IDLE;
      end
      ST_FAIL: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_pop_o   = (state_q == ST_IDLE) && cmd_valid_i;
    busy_o      = (state_q != ST_IDLE);
    rsp_valid_o = (state_q == ST_EMIT) || (state_q == ST_FAIL);
    rsp_o.found          = (state_q == ST_EMIT);
    rsp_o.witness_vertex = (state_q == ST_EMIT) ? vs_rd : 5'd0;
    rsp_o.last           = (state_q == ST_FAIL) || (k_q + 6'd1 == cnt);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pop_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pop_q   <= pop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) cmd_q <= cmd_i;
    s_q <= s_d; d_q <= d_d; nxt_q <= nxt_d; cur_q <= cur_d; vis_q <= vis_d; k_q <= k_d;
  end
endmodule

### tb/sv/tb.sv
// Testbench for the exact-length cycle and path search block.
`timescale 1ns / 100ps

module tb;
  import elcps_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int SETTLE_CYCLES  = 40;

  // Mirror the graph and the search engine, queue the expected results and
  // compare each result that leaves the block.
  class search_scoreboard;
    bit [31:0]   adj_rows[32];
    int unsigned vcount;
    int          walk_v[33];
    int          walk_n[33];
    rsp_t        expected_q[$];
    int          errors;
    int          n_requests;
    int          n_found;
    int          n_missed;

    function new();
      foreach (adj_rows[i]) adj_rows[i] = '0;
      vcount = 32;
    endfunction

    function void set_count(int unsigned v);
      vcount = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Depth-first search for a simple cycle through s, moving only to
    // vertices at or above s, lowest first.
    function bit cycle_from(int s, int len, int n);
      int d;
      int cur;
      int w;
      bit adv;
      bit [31:0] seen;
      d = 0;
      seen = '0;
      seen[s] = 1'b1;
      walk_v[0] = s;
      walk_n[0] = s;
      forever begin
        cur = walk_v[d];
        adv = 1'b0;
        if (d == len - 1) begin
          if (adj_rows[cur][s]) return 1'b1;
        end else begin
          for (w = walk_n[d]; w < n && !adv; w++) begin
            if (adj_rows[cur][w] && !seen[w]) begin
              walk_n[d] = w + 1;
              d++;
              walk_v[d] = w;
              walk_n[d] = s;
              seen[w] = 1'b1;
              adv = 1'b1;
            end
          end
        end
        if (!adv) begin
          if (d == 0) return 1'b0;
          seen[walk_v[d]] = 1'b0;
          d--;
        end
      end
    endfunction

    // Depth-first search for a simple path u to v of exactly len edges; the
    // target is only entered as the final step.
    function bit path_walk(int u, int v, int len, int n);
      int d;
      int cur;
      int w;
      bit adv;
      bit [31:0] seen;
      d = 0;
      seen = '0;
      seen[u] = 1'b1;
      walk_v[0] = u;
      walk_n[0] = 0;
      forever begin
        cur = walk_v[d];
        adv = 1'b0;
        if (d == len) begin
          if (cur == v) return 1'b1;
        end else begin
          for (w = walk_n[d]; w < n && !adv; w++) begin
            if (adj_rows[cur][w] && !seen[w] && !(w == v && len - d != 1)) begin
              walk_n[d] = w + 1;
              d++;
              walk_v[d] = w;
              walk_n[d] = 0;
              seen[w] = 1'b1;
              adv = 1'b1;
            end
          end
        end
        if (!adv) begin
          if (d == 0) return 1'b0;
          seen[walk_v[d]] = 1'b0;
          d--;
        end
      end
    endfunction

    function void queue_witness(bit hit, int count);
      rsp_t r;
      if (!hit || count == 0 || count > 32) begin
        r = '{found: 1'b0, witness_vertex: 5'd0, last: 1'b1};
        expected_q.push_back(r);
        n_missed++;
        return;
      end
      n_found++;
      for (int k = 0; k < count; k++) begin
        r.found          = 1'b1;
        r.witness_vertex = walk_v[k][4:0];
        r.last           = (k + 1 == count);
        expected_q.push_back(r);
      end
    endfunction

    function void note_request(req_t r);
      int n;
      int len;
      bit hit;
      n = (vcount > 32) ? 32 : vcount;
      len = r.length;
      hit = 1'b0;
      n_requests++;
      case (r.opcode)
        OP_EDGE: begin
          if (r.vertex_a != r.vertex_b) begin
            adj_rows[r.vertex_a][r.vertex_b] = r.edge_present;
            adj_rows[r.vertex_b][r.vertex_a] = r.edge_present;
          end
        end
        OP_CLEAR: begin
          foreach (adj_rows[i]) adj_rows[i] = '0;
        end
        OP_CYCLE: begin
          if (len >= 3 && len <= n)
            for (int s = 0; s < n && !hit; s++) hit = cycle_from(s, len, n);
          queue_witness(hit, len);
        end
        default: begin
          if (r.vertex_a < n && r.vertex_b < n && len + 1 <= n)
            hit = path_walk(r.vertex_a, r.vertex_b, len, n);
          queue_witness(hit, len + 1);
        end
      endcase
    endfunction

    task report(string what);
      errors++;
      $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    task check_result(rsp_t got);
      rsp_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result %p", got));
        return;
      end
      want = expected_q.pop_front();
      if (got.found !== want.found)
        report($sformatf("found %0b, want %0b", got.found, want.found));
      if (got.witness_vertex !== want.witness_vertex)
        report($sformatf("witness_vertex %0d, want %0d",
                         got.witness_vertex, want.witness_vertex));
      if (got.last !== want.last)
        report($sformatf("last %0b, want %0b", got.last, want.last));
    endtask
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  req_t       req_i = '0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [5:0] cfg_data_i = '0;
  logic       result_valid_o;
  rsp_t       result_o;

  search_scoreboard sb = new();
  int unsigned cur_count = 32;
  int          idle_cycles = 0;

  always #1 clk_i = ~clk_i;

  exact_length_cycle_path_search dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  // Check every result in the cycle it is presented; it cannot be held off.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) sb.check_result(result_o);
  end

  // Count cycles in which nothing moves; a stuck search ends the run.
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", sb.pending());
        $display("exact_length_cycle_path_search test failed");
        $finish;
      end
    end
  end

  // Draw a gap length: mostly none or short, a few long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Drop start and wait until every expected result has come, then let the
  // engine settle before the graph or the vertex count changes.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Present one request; start stays high across back-to-back requests.
  task automatic send(req_t r);
    int gap;
    if (r.opcode == OP_EDGE || r.opcode == OP_CLEAR) drain();
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    sb.note_request(r);
  endtask

  task automatic write_count(int unsigned v);
    drain();
    repeat (pick_gap()) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v[5:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_count(v);
    cur_count = v;
  endtask

  function automatic req_t make_req(opcode_e op, int a, int b, bit p, int len);
    req_t r;
    r.opcode       = op;
    r.vertex_a     = a[4:0];
    r.vertex_b     = b[4:0];
    r.edge_present = p;
    r.length       = len[5:0];
    return r;
  endfunction

  // Pick a vertex: mostly inside the active range, sometimes anywhere.
  function automatic int pick_vertex();
    if ($urandom_range(0, 99) < 88) return $urandom_range(0, cur_count - 1);
    return $urandom_range(0, 31);
  endfunction

  task automatic random_phase();
    int unsigned roll;
    int n_edges;
    int len;
    roll = $urandom_range(0, 99);
    if (roll < 10)      write_count(1);
    else if (roll < 25) write_count(32);
    else                write_count($urandom_range(2, 8));
    send(make_req(OP_CLEAR, $urandom_range(0, 31), $urandom_range(0, 31),
                  1'($urandom_range(0, 1)), $urandom_range(0, 63)));
    // Keep large graphs sparse so that failing searches stay short.
    n_edges = (cur_count == 32) ? $urandom_range(6, 14) : $urandom_range(2, 2 * cur_count + 2);
    repeat (n_edges) begin
      send(make_req(OP_EDGE, pick_vertex(), pick_vertex(),
                    $urandom_range(0, 99) < 80, $urandom_range(0, 63)));
    end
    repeat ($urandom_range(6, 12)) begin
      if ($urandom_range(0, 99) < 80) len = $urandom_range(0, cur_count + 1);
      else                            len = $urandom_range(0, 63);
      send(make_req($urandom_range(0, 1) ? OP_CYCLE : OP_PATH,
                    pick_vertex(), pick_vertex(), 1'($urandom_range(0, 1)), len));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: self loop, edge add and remove at the top vertex, a triangle.
    send(make_req(OP_EDGE, 5, 5, 1'b1, 0));
    send(make_req(OP_EDGE, 0, 31, 1'b1, 63));
    send(make_req(OP_PATH, 0, 31, 1'b0, 1));
    send(make_req(OP_EDGE, 31, 0, 1'b0, 0));
    send(make_req(OP_PATH, 0, 31, 1'b0, 1));
    send(make_req(OP_EDGE, 0, 1, 1'b1, 0));
    send(make_req(OP_EDGE, 1, 2, 1'b1, 0));
    send(make_req(OP_EDGE, 2, 0, 1'b1, 0));
    send(make_req(OP_CYCLE, 0, 0, 1'b0, 3));
    send(make_req(OP_CYCLE, 0, 0, 1'b0, 2));   // too short for a cycle
    send(make_req(OP_CYCLE, 0, 0, 1'b0, 0));
    send(make_req(OP_CYCLE, 0, 0, 1'b0, 33));  // longer than the graph
    send(make_req(OP_CYCLE, 31, 31, 1'b1, 63));
    send(make_req(OP_PATH, 0, 2, 1'b0, 2));
    send(make_req(OP_PATH, 0, 0, 1'b0, 0));    // same endpoints, empty path
    send(make_req(OP_PATH, 1, 1, 1'b0, 2));    // same endpoints, nonzero length
    send(make_req(OP_PATH, 0, 1, 1'b0, 31));
    send(make_req(OP_PATH, 0, 1, 1'b0, 32));
    write_count(3);
    send(make_req(OP_PATH, 0, 5, 1'b0, 1));    // target outside the active range
    send(make_req(OP_CYCLE, 0, 0, 1'b0, 3));
    send(make_req(OP_CYCLE, 0, 0, 1'b0, 4));
    send(make_req(OP_CLEAR, 31, 31, 1'b1, 63));
    send(make_req(OP_CYCLE, 0, 0, 1'b0, 3));
    write_count(1);
    send(make_req(OP_PATH, 0, 0, 1'b0, 0));

    // Random phases, each with its own vertex count and graph.
    while (sb.n_requests < 255) random_phase();

    drain();
    $display("requests: %0d, queries found: %0d, queries not found: %0d",
             sb.n_requests, sb.n_found, sb.n_missed);
    $display("last vertex count %0d, mismatches %0d", cur_count, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("exact_length_cycle_path_search test passed");
    end else begin
      $display("exact_length_cycle_path_search test failed");
    end
    $finish;
  end

endmodule
